FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL of the tail motor drive.
// Needs no other file; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked on every rising edge of clk, off while rst_n is low.
`define OTMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define OTMD_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OTMD_ASSERT(lbl, prop, msg)
`define OTMD_ASSERT_NR(lbl, prop, msg)
`endif

`endif

FILE: sv/otmd_pkg.sv
// Package for the oscillating tail motor drive: fixed-point constants,
// microcode types, the control store and the sine table builder. No dependencies.
`default_nettype none

package otmd_pkg;

  localparam int FRAC_BITS           = 15;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int Q_ONE               = 1 << FRAC_BITS;
  localparam int C_005               = ((5 << FRAC_BITS) + 50) / 100;
  localparam int C_003               = ((3 << FRAC_BITS) + 50) / 100;
  localparam int C_001               = ((1 << FRAC_BITS) + 50) / 100;
  localparam int GAIN_FRAC           = 12;
  localparam int PROD_W              = 52;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_TICK_PERIOD = 2'd0;
  localparam cfg_idx_t CFG_SHUTOFF_LEAD = 2'd1;
  localparam cfg_idx_t CFG_WAVE_GAIN = 2'd2;

  // microcode
  typedef logic [3:0] step_t;
  localparam step_t STEP_FETCH  = 4'd0;
  localparam step_t STEP_TICK   = 4'd1;
  localparam step_t STEP_SC_MUL = 4'd2;
  localparam step_t STEP_SC_SET = 4'd3;
  localparam step_t STEP_PHASE  = 4'd4;
  localparam step_t STEP_SINE   = 4'd5;
  localparam step_t STEP_G_MUL  = 4'd6;
  localparam step_t STEP_WAVE   = 4'd7;
  localparam step_t STEP_D_MUL  = 4'd8;
  localparam step_t STEP_EMIT   = 4'd9;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_WAIT_IN,
    OP_TICK,
    OP_STROKE,
    OP_SINE,
    OP_WAVE,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_STROKE,
    MUL_PHASE,
    MUL_GAIN,
    MUL_DRIVE
  } mul_sel_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_NO_SWITCH,
    JMP_ALWAYS
  } jmp_t;

  typedef struct packed {
    op_t      op;
    mul_sel_t mul;
    jmp_t     jmp;
    step_t    target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    w = '{op: OP_NOP, mul: MUL_NONE, jmp: JMP_ALWAYS, target: STEP_FETCH};
    unique case (s)
      STEP_FETCH:  w = '{op: OP_WAIT_IN, mul: MUL_NONE, jmp: JMP_NONE, target: STEP_FETCH};
      STEP_TICK:   w = '{op: OP_TICK, mul: MUL_NONE, jmp: JMP_NONE, target: STEP_FETCH};
      STEP_SC_MUL: w = '{op: OP_NOP, mul: MUL_STROKE, jmp: JMP_NO_SWITCH, target: STEP_PHASE};
      STEP_SC_SET: w = '{op: OP_STROKE, mul: MUL_NONE, jmp: JMP_NONE, target: STEP_FETCH};
      STEP_PHASE:  w = '{op: OP_NOP, mul: MUL_PHASE, jmp: JMP_NONE, target: STEP_FETCH};
      STEP_SINE:   w = '{op: OP_SINE, mul: MUL_NONE, jmp: JMP_NONE, target: STEP_FETCH};
      STEP_G_MUL:  w = '{op: OP_NOP, mul: MUL_GAIN, jmp: JMP_NONE, target: STEP_FETCH};
      STEP_WAVE:   w = '{op: OP_WAVE, mul: MUL_NONE, jmp: JMP_NONE, target: STEP_FETCH};
      STEP_D_MUL:  w = '{op: OP_NOP, mul: MUL_DRIVE, jmp: JMP_NONE, target: STEP_FETCH};
      STEP_EMIT:   w = '{op: OP_EMIT, mul: MUL_NONE, jmp: JMP_ALWAYS, target: STEP_FETCH};
      default:     w = '{op: OP_NOP, mul: MUL_NONE, jmp: JMP_ALWAYS, target: STEP_FETCH};
    endcase
    return w;
  endfunction

  // round to nearest, ties away from zero, then shift right by s
  function automatic logic signed [PROD_W-1:0] rnd_shift(input logic signed [PROD_W-1:0] v,
                                                         input int unsigned s);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] res;
    mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
    res = (mag + (PROD_W'(1) << (s - 1))) >> s;
    return v[PROD_W-1] ? -$signed(res) : $signed(res);
  endfunction

  // floor(t / ((2n)(2n+1))) for n = 1..6 by reciprocal multiplication:
  // factor is 2^42 / divisor rounded up, exact for every t below 2^34
  function automatic longint unsigned series_div(input longint unsigned t, input int n);
    logic [39:0]  recip;
    logic [127:0] prod;
    unique case (n)
      1:       recip = 40'd733007751851;  // divisor 6
      2:       recip = 40'd219902325556;  // divisor 20
      3:       recip = 40'd104715393122;  // divisor 42
      4:       recip = 40'd61083979321;   // divisor 72
      5:       recip = 40'd39982241011;   // divisor 110
      6:       recip = 40'd28192605841;   // divisor 156
      default: recip = '0;
    endcase
    prod = 128'(t) * 128'(recip);
    return prod[105:42];
  endfunction

  // round(sin(m*pi/(2*Q)) * ONE), Q = 2^(stb-2); Taylor series in Q30
  function automatic logic [15:0] quarter_sine(input int unsigned m, input int unsigned stb);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    longint          half;
    x = (HALF_PI_Q30 * longint'(m)) >> (stb - 2);
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = series_div(term, n);
      sum = ((n & 1) != 0) ? sum - longint'(term) : sum + longint'(term);
    end
    half = longint'(1) <<< (30 - FRAC_BITS - 1);
    if (sum < 0) sum = -((-sum + half) >>> (30 - FRAC_BITS));
    else         sum = (sum + half) >>> (30 - FRAC_BITS);
    if (sum < 0) sum = 0;
    if (sum > Q_ONE) sum = Q_ONE;
    return 16'(sum);
  endfunction

endpackage

`default_nettype wire

FILE: sv/otmd_in_if.sv
// Input channel of the tail motor drive: one control tick per item.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface otmd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pending_yaw;
  logic [15:0]        pending_thrust;
  logic [15:0]        pending_pitch;
  logic [23:0]        pending_rate;
  logic [23:0]        pending_half_period;

  modport source (output valid, pending_yaw, pending_thrust, pending_pitch, pending_rate,
                  pending_half_period, input ready);
  modport sink (input valid, pending_yaw, pending_thrust, pending_pitch, pending_rate,
                pending_half_period, output ready);
endinterface

`default_nettype wire

FILE: sv/otmd_out_if.sv
// Result channel of the tail motor drive: drive and servo commands per tick.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface otmd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] drive_magnitude;
  logic        drive_reverse;
  logic [15:0] servo_left_pos;
  logic [15:0] servo_right_pos;
  logic        aux_motor_off;

  modport source (output valid, drive_magnitude, drive_reverse, servo_left_pos,
                  servo_right_pos, aux_motor_off, input ready);
  modport sink (input valid, drive_magnitude, drive_reverse, servo_left_pos,
                servo_right_pos, aux_motor_off, output ready);
endinterface

`default_nettype wire

FILE: sv/oscillating_tail_motor_drive_top.sv
// Top level of the oscillating tail motor drive: microcoded datapath.
// Uses otmd_pkg, otmd_in_if, otmd_out_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Oscillating tail motor drive. Each input item is one control tick: it
// advances the elapsed stroke time by tick_period_us, flips stroke when the
// latched half period is passed (latching yaw, and every full cycle thrust,
// rate and half period), and returns one result item with the bridge drive
// (Q1.15 magnitude plus reverse bit), both fin servo positions and the aux
// motor shutoff flag. The work runs as a ten-step microprogram on one shared
// 26x26 multiplier, used four times per item (stroke command, phase, gain,
// drive). The stroke-set step runs only when the stroke switches; the next
// item can be accepted in the cycle after the result is loaded into the output
// register, so no item is taken before the previous one is through. The
// result register lets the next item enter while a result waits; the program
// stalls in its last step only if the previous result is still not taken.
// Config writes (cfg_we, cfg_index, cfg_wdata) take effect on the next edge
// and belong to idle time. The sine is a quarter-wave constant table of
// 2^(SINE_TABLE_BITS-2)+1 entries with a registered read.
module oscillating_tail_motor_drive_top #(
  parameter int SINE_TABLE_BITS = otmd_pkg::SINE_TABLE_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_we,
  input  wire [1:0]           cfg_index,
  input  wire [23:0]          cfg_wdata,
  otmd_in_if.sink             in_ch,
  otmd_out_if.source          out_ch
);

  localparam int QTR = 2 ** (SINE_TABLE_BITS - 2);
  localparam int PW  = otmd_pkg::PROD_W;
  localparam logic [15:0]        ONE_U16  = 16'(otmd_pkg::Q_ONE);
  localparam logic signed [16:0] ONE_S17  = 17'(otmd_pkg::Q_ONE);
  localparam logic signed [PW-1:0] ONE_SP = PW'(otmd_pkg::Q_ONE);
  localparam logic [15:0]        C005_U16 = 16'(otmd_pkg::C_005);
  localparam logic [15:0]        C003_U16 = 16'(otmd_pkg::C_003);
  localparam logic signed [16:0] C001_S17 = 17'(otmd_pkg::C_001);
  localparam logic signed [18:0] FOUR_ONE = 19'(4 * otmd_pkg::Q_ONE);

  // ---------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------
  logic [15:0] tick_r;
  logic [23:0] lead_r;
  logic [15:0] gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= 16'd1000;
      lead_r <= 24'd30000;
      gain_r <= 16'd14336;
    end else if (cfg_we) begin
      case (cfg_index)
        otmd_pkg::CFG_TICK_PERIOD:  tick_r <= cfg_wdata[15:0];
        otmd_pkg::CFG_SHUTOFF_LEAD: lead_r <= cfg_wdata;
        otmd_pkg::CFG_WAVE_GAIN:    gain_r <= cfg_wdata[15:0];
        default: ;  // index beyond the register list: ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: step counter plus control store
  // ---------------------------------------------------------------------
  otmd_pkg::step_t  step_r, step_nxt;
  otmd_pkg::ucode_t uc;
  logic             out_valid_r, out_valid_nxt;
  logic             switch_r;
  logic             in_fire, hold, jump_take, emit_go;

  assign uc        = otmd_pkg::ucode_rom(step_r);
  assign in_ch.ready = (uc.op == otmd_pkg::OP_WAIT_IN);
  assign in_fire   = in_ch.valid && in_ch.ready;

  always_comb begin
    hold = ((uc.op == otmd_pkg::OP_WAIT_IN) && !in_fire) ||
           ((uc.op == otmd_pkg::OP_EMIT) && out_valid_r && !out_ch.ready);
    jump_take = (uc.jmp == otmd_pkg::JMP_ALWAYS) ||
                ((uc.jmp == otmd_pkg::JMP_NO_SWITCH) && !switch_r);
    emit_go = (uc.op == otmd_pkg::OP_EMIT) && !hold;
    if (hold)           step_nxt = step_r;
    else if (jump_take) step_nxt = uc.target;
    else                step_nxt = otmd_pkg::step_t'(step_r + 1'b1);
    out_valid_nxt = (out_valid_r && !out_ch.ready) || emit_go;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= otmd_pkg::STEP_FETCH;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Item capture
  // ---------------------------------------------------------------------
  logic signed [15:0] yaw_in_r;
  logic [15:0]        thrust_in_r, pitch_in_r;
  logic [23:0]        rate_in_r, half_in_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      yaw_in_r    <= in_ch.pending_yaw;
      thrust_in_r <= (in_ch.pending_thrust > ONE_U16) ? ONE_U16 : in_ch.pending_thrust;
      pitch_in_r  <= (in_ch.pending_pitch > ONE_U16) ? ONE_U16 : in_ch.pending_pitch;
      rate_in_r   <= in_ch.pending_rate;
      half_in_r   <= in_ch.pending_half_period;
    end
  end

  // ---------------------------------------------------------------------
  // Stroke state
  // ---------------------------------------------------------------------
  logic [24:0]        elapsed_r;
  logic [23:0]        half_r, rate_r;
  logic signed [15:0] yaw_r;
  logic [15:0]        thrust_r;
  logic signed [16:0] stroke_r;
  logic               upstroke_r;

  logic [24:0]        elapsed_sum;
  logic signed [25:0] aux_lim;
  logic               aux_now, switch_now;

  always_comb begin
    elapsed_sum = elapsed_r + {9'd0, tick_r};
    aux_lim     = $signed({2'b00, half_r}) - $signed({2'b00, lead_r});
    aux_now     = $signed({1'b0, elapsed_sum}) > aux_lim;  // before any latching
    switch_now  = elapsed_sum > {1'b0, half_r};
  end

  // shared multiplier; its product register feeds every following step
  logic signed [PW-1:0] prod_r;
  logic signed [25:0]   mul_a, mul_b;
  logic signed [18:0]   yaw_ext, yaw_x3, coef;
  logic signed [16:0]   sine_r, w_r;

  always_comb begin
    yaw_ext = {{3{yaw_r[15]}}, yaw_r};
    yaw_x3  = (yaw_ext <<< 1) + yaw_ext;
    // upstroke weakened by negative yaw, downstroke by positive yaw
    if (upstroke_r) coef = yaw_r[15] ? FOUR_ONE + yaw_x3 : FOUR_ONE;
    else            coef = (!yaw_r[15] && (yaw_r != '0)) ? FOUR_ONE - yaw_x3 : FOUR_ONE;
    mul_a = '0;
    mul_b = '0;
    unique case (uc.mul)
      otmd_pkg::MUL_NONE: ;
      otmd_pkg::MUL_STROKE: begin
        mul_a = {{7{coef[18]}}, coef};
        mul_b = {10'd0, thrust_r};
      end
      otmd_pkg::MUL_PHASE: begin
        mul_a = {2'b00, rate_r};
        mul_b = {1'b0, elapsed_r};
      end
      otmd_pkg::MUL_GAIN: begin
        mul_a = {10'd0, gain_r};
        mul_b = {{9{sine_r[16]}}, sine_r};
      end
      otmd_pkg::MUL_DRIVE: begin
        mul_a = {{9{w_r[16]}}, w_r};
        mul_b = {{9{stroke_r[16]}}, stroke_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (uc.mul != otmd_pkg::MUL_NONE) prod_r <= mul_a * mul_b;
  end

  // stroke command from the product, rounded from Q(F+2)
  logic signed [PW-1:0] sc_rnd;
  logic signed [16:0]   sc_mag;
  assign sc_rnd = otmd_pkg::rnd_shift(prod_r, otmd_pkg::FRAC_BITS + 2);
  assign sc_mag = sc_rnd[16:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r  <= '0;
      half_r     <= '0;
      rate_r     <= '0;
      yaw_r      <= '0;
      thrust_r   <= '0;
      stroke_r   <= '0;
      upstroke_r <= 1'b1;
    end else begin
      unique case (uc.op)
        otmd_pkg::OP_TICK: begin
          if (switch_now) begin
            yaw_r     <= yaw_in_r;
            elapsed_r <= '0;
            if (upstroke_r) begin
              thrust_r <= thrust_in_r;
              rate_r   <= rate_in_r;
              half_r   <= half_in_r;
            end
          end else begin
            elapsed_r <= elapsed_sum;
          end
        end
        otmd_pkg::OP_STROKE: begin
          stroke_r   <= upstroke_r ? sc_mag : -sc_mag;
          upstroke_r <= !upstroke_r;
        end
        otmd_pkg::OP_NOP, otmd_pkg::OP_WAIT_IN, otmd_pkg::OP_SINE,
        otmd_pkg::OP_WAVE, otmd_pkg::OP_EMIT: ;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sine lookup: quarter-wave constant table, sign and mirror by quadrant
  // ---------------------------------------------------------------------
  logic [15:0] qsin_rom [QTR+1];

  for (genvar k = 0; k <= QTR; k++) begin : g_qsin
    assign qsin_rom[k] = otmd_pkg::quarter_sine(k, SINE_TABLE_BITS);
  end

  logic [SINE_TABLE_BITS-1:0] phase_idx;
  logic [SINE_TABLE_BITS-3:0] phase_low;
  logic [SINE_TABLE_BITS-2:0] qtr_addr;
  logic [15:0]                qsin_val;

  always_comb begin
    phase_idx = prod_r[31 -: SINE_TABLE_BITS];  // phase is the product mod 2^32
    phase_low = phase_idx[SINE_TABLE_BITS-3:0];
    qtr_addr  = phase_idx[SINE_TABLE_BITS-2]
              ? (SINE_TABLE_BITS-1)'(QTR) - {1'b0, phase_low}
              : {1'b0, phase_low};
    qsin_val  = qsin_rom[qtr_addr];
  end

  // ---------------------------------------------------------------------
  // Sine, wave and result registers
  // ---------------------------------------------------------------------
  logic signed [PW-1:0] w_rnd, d_rnd;
  logic signed [16:0]   d_val, d_dz, d_abs;
  logic                 switch_unused_n;
  logic                 aux_r;
  logic [15:0]          left_val, right_diff, right_val;

  assign w_rnd = otmd_pkg::rnd_shift(prod_r, otmd_pkg::GAIN_FRAC);
  assign d_rnd = otmd_pkg::rnd_shift(prod_r, otmd_pkg::FRAC_BITS);
  assign switch_unused_n = 1'b1;

  always_comb begin
    d_val = d_rnd[16:0];
    d_dz  = ((d_val > -C001_S17) && (d_val < C001_S17)) ? '0 : d_val;  // dead zone
    d_abs = d_dz[16] ? -d_dz : d_dz;
    left_val   = (pitch_in_r >= C005_U16) ? pitch_in_r - C005_U16 : '0;
    right_diff = ONE_U16 - pitch_in_r;
    right_val  = (right_diff < C003_U16) ? C003_U16 : right_diff;
  end

  logic [15:0] mag_r, left_r, right_r;
  logic        rev_r, aux_out_r;

  always_ff @(posedge clk) begin
    if (uc.op == otmd_pkg::OP_TICK) begin
      aux_r    <= aux_now;
      switch_r <= switch_now && switch_unused_n;
    end
    if (uc.op == otmd_pkg::OP_SINE) begin
      sine_r <= phase_idx[SINE_TABLE_BITS-1] ? -$signed({1'b0, qsin_val})
                                             : $signed({1'b0, qsin_val});
    end
    if (uc.op == otmd_pkg::OP_WAVE) begin
      if (w_rnd > ONE_SP)       w_r <= ONE_S17;
      else if (w_rnd < -ONE_SP) w_r <= -ONE_S17;
      else                      w_r <= w_rnd[16:0];
    end
    if (emit_go) begin
      mag_r     <= (d_abs > ONE_S17) ? ONE_U16 : d_abs[15:0];
      rev_r     <= d_dz[16];
      left_r    <= left_val;
      right_r   <= right_val;
      aux_out_r <= aux_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.drive_magnitude = mag_r;
  assign out_ch.drive_reverse   = rev_r;
  assign out_ch.servo_left_pos  = left_r;
  assign out_ch.servo_right_pos = right_r;
  assign out_ch.aux_motor_off   = aux_out_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `OTMD_ASSERT(a_elapsed_cleared, (uc.op == otmd_pkg::OP_STROKE) |-> (elapsed_r == '0), "stroke set without cleared elapsed time")
  `OTMD_ASSERT(a_dir_toggle, !$stable(upstroke_r) |-> $past(uc.op == otmd_pkg::OP_STROKE), "stroke direction changed outside the stroke step")
  `OTMD_ASSERT(a_emit_source, $rose(out_valid_r) |-> $past(uc.op == otmd_pkg::OP_EMIT), "result valid without an emit step")
  `OTMD_ASSERT(a_wave_clip, (uc.mul == otmd_pkg::MUL_DRIVE) |-> ((w_r <= ONE_S17) && (w_r >= -ONE_S17)), "wave not clipped to plus or minus one")
  `OTMD_ASSERT_NR(a_reset_quiet, !rst_n |=> !out_valid_r, "result valid right after reset")

endmodule

`default_nettype wire
